// ===== rtl/core/traffic_phase_sequencer_ped_request_assert.svh =====
// Assertion macros for the traffic phase sequencer.
// Included by the modules that check their own logic; no other dependencies.
`ifndef TRAFFIC_PHASE_SEQUENCER_PED_REQUEST_ASSERT_SVH
`define TRAFFIC_PHASE_SEQUENCER_PED_REQUEST_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define TPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tps assertion failed");

// antecedent implies consequent in the next cycle
`define TPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tps assertion failed");

`else

`define TPS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TPS_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/tps_pkg.sv =====
// Shared types, constants and phase tables for the traffic phase sequencer.
// No dependencies.
package tps_pkg;

    localparam int COUNT_WIDTH = 12;
    localparam int NUM_PHASES  = 6;
    localparam int BASE_W      = 12;
    localparam int ADJ_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int LAMP_W      = 2;
    localparam int PIDX_W      = 3;
    localparam int SUM_W       = ((BASE_W > COUNT_WIDTH) ? BASE_W : COUNT_WIDTH) + 2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_FIVE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_SIX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ADJ    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_ADJ   = 3'd7;

    // register reset values
    localparam logic [BASE_W-1:0] RST_PHASE_ONE   = 12'd100;
    localparam logic [BASE_W-1:0] RST_PHASE_TWO   = 12'd200;
    localparam logic [BASE_W-1:0] RST_PHASE_THREE = 12'd200;
    localparam logic [BASE_W-1:0] RST_PHASE_FOUR  = 12'd100;
    localparam logic [BASE_W-1:0] RST_PHASE_FIVE  = 12'd200;
    localparam logic [BASE_W-1:0] RST_PHASE_SIX   = 12'd200;
    localparam logic [ADJ_W-1:0]  RST_LONG_ADJ    = 11'd75;
    localparam logic [ADJ_W-1:0]  RST_SHORT_ADJ   = 11'd25;

    // lamp colors
    localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd0;
    localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd1;
    localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd2;

    typedef enum logic [NUM_PHASES-1:0] {
        PH_ALL_RED_A    = 6'b000001,
        PH_CROSS_GREEN  = 6'b000010,
        PH_CROSS_YELLOW = 6'b000100,
        PH_ALL_RED_B    = 6'b001000,
        PH_MAIN_GREEN   = 6'b010000,
        PH_MAIN_YELLOW  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        ADJ_NONE      = 2'd0,
        ADJ_ADD_LONG  = 2'd1,
        ADJ_SUB_LONG  = 2'd2,
        ADJ_SUB_SHORT = 2'd3
    } adj_t;

    typedef struct packed {
        logic [LAMP_W-1:0] main_lamp;
        logic [LAMP_W-1:0] cross_lamp;
        logic              walk_on;
        logic [PIDX_W-1:0] phase_index;
    } lamp_out_t;

    function automatic phase_t next_phase(input phase_t ph);
        phase_t nxt;
        unique case (ph)
            PH_ALL_RED_A:    nxt = PH_CROSS_GREEN;
            PH_CROSS_GREEN:  nxt = PH_CROSS_YELLOW;
            PH_CROSS_YELLOW: nxt = PH_ALL_RED_B;
            PH_ALL_RED_B:    nxt = PH_MAIN_GREEN;
            PH_MAIN_GREEN:   nxt = PH_MAIN_YELLOW;
            default:         nxt = PH_ALL_RED_A;
        endcase
        return nxt;
    endfunction

    // phases whose pending adjustment a request during this phase sets
    function automatic logic [NUM_PHASES-1:0] press_mask(input phase_t ph);
        logic [NUM_PHASES-1:0] m;
        unique case (ph)
            PH_ALL_RED_A:    m = 6'b011110;
            PH_CROSS_GREEN:  m = 6'b011100;
            PH_CROSS_YELLOW: m = 6'b011000;
            PH_ALL_RED_B:    m = 6'b010000;
            PH_MAIN_GREEN:   m = 6'b101111;
            PH_MAIN_YELLOW:  m = 6'b011111;
            default:         m = '0;
        endcase
        return m;
    endfunction

    // each phase always gets the same kind of adjustment
    function automatic adj_t phase_adj(input phase_t ph);
        adj_t a;
        unique case (ph)
            PH_ALL_RED_A, PH_ALL_RED_B:                      a = ADJ_SUB_SHORT;
            PH_CROSS_GREEN, PH_CROSS_YELLOW, PH_MAIN_YELLOW: a = ADJ_SUB_LONG;
            PH_MAIN_GREEN:                                   a = ADJ_ADD_LONG;
            default:                                         a = ADJ_NONE;
        endcase
        return a;
    endfunction

    function automatic lamp_out_t phase_lamps(input phase_t ph);
        lamp_out_t o;
        o = '{main_lamp: LAMP_RED, cross_lamp: LAMP_RED, walk_on: 1'b0, phase_index: '0};
        unique case (ph)
            PH_ALL_RED_A:    o.phase_index = 3'd0;
            PH_CROSS_GREEN: begin
                o.cross_lamp  = LAMP_GREEN;
                o.phase_index = 3'd1;
            end
            PH_CROSS_YELLOW: begin
                o.cross_lamp  = LAMP_YELLOW;
                o.phase_index = 3'd2;
            end
            PH_ALL_RED_B:    o.phase_index = 3'd3;
            PH_MAIN_GREEN: begin
                o.main_lamp   = LAMP_GREEN;
                o.walk_on     = 1'b1;
                o.phase_index = 3'd4;
            end
            PH_MAIN_YELLOW: begin
                o.main_lamp   = LAMP_YELLOW;
                o.phase_index = 3'd5;
            end
            default:         o.phase_index = '0;
        endcase
        return o;
    endfunction

    // base plus adjustment, clamped to 1 .. COUNT_MAX
    function automatic logic [COUNT_WIDTH-1:0] latch_len(
        input logic [BASE_W-1:0] base,
        input adj_t              adj,
        input logic [ADJ_W-1:0]  long_adj,
        input logic [ADJ_W-1:0]  short_adj
    );
        logic signed [SUM_W-1:0] len;
        logic [COUNT_WIDTH-1:0]  res;
        len = SUM_W'(base);
        unique case (adj)
            ADJ_ADD_LONG:  len = len + SUM_W'(long_adj);
            ADJ_SUB_LONG:  len = len - SUM_W'(long_adj);
            ADJ_SUB_SHORT: len = len - SUM_W'(short_adj);
            default:       len = len;
        endcase
        if (len < $signed(SUM_W'(1))) begin
            res = COUNT_WIDTH'(1);
        end else if (len > $signed(SUM_W'(COUNT_MAX))) begin
            res = COUNT_MAX;
        end else begin
            res = len[COUNT_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/traffic_phase_sequencer_ped_request.sv =====
// The result of an accepted tick request appears on the m_ side in the next cycle.
// Throughput: one tick per cycle; the phase state updates in the accept cycle and
// the result sits in an output register, so input stalls only when that register
// is full and not being taken.
// Reset (aresetn low, synchronous): phase one, tick count zero, no pending
// adjustments, registers at their defaults, output empty.
`include "traffic_phase_sequencer_ped_request_assert.svh"

module traffic_phase_sequencer_ped_request (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [tps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // tick requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_ped_button,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tps_pkg::LAMP_W-1:0]        m_main_lamp,
    output logic [tps_pkg::LAMP_W-1:0]        m_cross_lamp,
    output logic                              m_walk_on,
    output logic [tps_pkg::PIDX_W-1:0]        m_phase_index,
    output logic                              m_phase_end
);
    import tps_pkg::*;

    logic [BASE_W-1:0]      base_len_reg [NUM_PHASES];
    logic [ADJ_W-1:0]       long_adj_reg;
    logic [ADJ_W-1:0]       short_adj_reg;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [COUNT_WIDTH-1:0] phase_length_reg, phase_length_next;
    logic [NUM_PHASES-1:0]  pend_reg, pend_next;

    logic                   m_valid_reg;
    lamp_out_t              lamps_reg;
    logic                   phase_end_reg;

    logic                   s_fire;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   done;
    logic [NUM_PHASES-1:0]  pend_press;
    phase_t                 adv_phase;
    logic [BASE_W-1:0]      adv_base;
    logic                   adv_pend;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        tick_inc   = tick_count_reg + COUNT_WIDTH'(1);
        // a stray phase code ends the phase at once
        done       = (tick_inc >= phase_length_reg) || (tick_inc == '0) || !$onehot(phase_reg);
        pend_press = pend_reg | (s_ped_button ? press_mask(phase_reg) : '0);
        adv_phase  = next_phase(phase_reg);

        adv_base = base_len_reg[0];
        adv_pend = pend_press[0];
        for (int i = 0; i < NUM_PHASES; i++) begin
            if (adv_phase[i]) begin
                adv_base = base_len_reg[i];
                adv_pend = pend_press[i];
            end
        end

        phase_next        = phase_reg;
        tick_count_next   = tick_inc;
        phase_length_next = phase_length_reg;
        pend_next         = pend_press;
        if (done) begin
            pend_next         = pend_press & ~phase_reg;
            phase_next        = adv_phase;
            tick_count_next   = '0;
            phase_length_next = latch_len(adv_base, adv_pend ? phase_adj(adv_phase) : ADJ_NONE,
                                          long_adj_reg, short_adj_reg);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg[0] <= RST_PHASE_ONE;
            base_len_reg[1] <= RST_PHASE_TWO;
            base_len_reg[2] <= RST_PHASE_THREE;
            base_len_reg[3] <= RST_PHASE_FOUR;
            base_len_reg[4] <= RST_PHASE_FIVE;
            base_len_reg[5] <= RST_PHASE_SIX;
            long_adj_reg    <= RST_LONG_ADJ;
            short_adj_reg   <= RST_SHORT_ADJ;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PHASE_ONE:   base_len_reg[0] <= cfg_wdata[BASE_W-1:0];
                REG_PHASE_TWO:   base_len_reg[1] <= cfg_wdata[BASE_W-1:0];
                REG_PHASE_THREE: base_len_reg[2] <= cfg_wdata[BASE_W-1:0];
                REG_PHASE_FOUR:  base_len_reg[3] <= cfg_wdata[BASE_W-1:0];
                REG_PHASE_FIVE:  base_len_reg[4] <= cfg_wdata[BASE_W-1:0];
                REG_PHASE_SIX:   base_len_reg[5] <= cfg_wdata[BASE_W-1:0];
                REG_LONG_ADJ:    long_adj_reg    <= cfg_wdata[ADJ_W-1:0];
                REG_SHORT_ADJ:   short_adj_reg   <= cfg_wdata[ADJ_W-1:0];
                default:         long_adj_reg    <= long_adj_reg;
            endcase
        end
    end

    // phase state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_ALL_RED_A;
            tick_count_reg   <= '0;
            phase_length_reg <= COUNT_WIDTH'(RST_PHASE_ONE);
            pend_reg         <= '0;
        end else if (s_fire) begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            phase_length_reg <= phase_length_next;
            pend_reg         <= pend_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            lamps_reg     <= phase_lamps(phase_reg);
            phase_end_reg <= done;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_main_lamp   = lamps_reg.main_lamp;
    assign m_cross_lamp  = lamps_reg.cross_lamp;
    assign m_walk_on     = lamps_reg.walk_on;
    assign m_phase_index = lamps_reg.phase_index;
    assign m_phase_end   = phase_end_reg;

    `TPS_ASSERT_NXT(a_done_restarts_count, aclk, aresetn, s_fire && done, tick_count_reg == '0)
    `TPS_ASSERT_NXT(a_phase_holds, aclk, aresetn, s_fire && !done, $stable(phase_reg))
    `TPS_ASSERT_IMP(a_length_nonzero, aclk, aresetn, 1'b1, phase_length_reg != '0)
    `TPS_ASSERT_NXT(a_fire_gives_result, aclk, aresetn, s_fire, m_valid_reg)

endmodule
